// ----- rtl/core/nvt_pkg.sv -----
package nvt_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int NAME_BYTES = 12;

  // Request kinds
  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_DEL = 1'b1
  } req_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_ADDED     = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DELETED   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // One table entry as held in a cell
  typedef struct packed {
    logic [63:0] name_low;
    logic [31:0] name_high;
    logic [31:0] value;
  } entry_t;

  // Per-cell control from the controller
  typedef struct packed {
    logic cap;    // capture match result for the incoming name
    logic shift;  // take the upper neighbor's entry
    logic load;   // take the request entry
  } cell_ctl_t;

  // String-style name compare: equal up to and including the first zero byte
  function automatic logic names_eq(input logic [95:0] a, input logic [95:0] b);
    logic       eq;
    logic       term;
    logic       be;
    logic [7:0] ab;
    eq   = 1'b1;
    term = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      ab = a[8*k +: 8];
      be = (ab == b[8*k +: 8]);
      if (!be && !term) eq = 1'b0;
      if (be && (ab == 8'd0)) term = 1'b1;
    end
    return eq;
  endfunction

endpackage

// ----- rtl/core/nvt_ifs.sv -----
// Request channel
interface nvt_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] name_low;
  logic [31:0] name_high;
  logic signed [31:0] entry_value;

  modport source (output valid, output req_type, output name_low, output name_high,
                  output entry_value, input ready);
  modport sink (input valid, input req_type, input name_low, input name_high,
                input entry_value, output ready);
endinterface

// Result channel
interface nvt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] position;
  logic [4:0] entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input position, input entry_count,
                output ready);
endinterface

// ----- rtl/core/nvt_cell.sv -----
module nvt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  nvt_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  nvt_pkg::entry_t    req_entry,
  input  nvt_pkg::entry_t    nb_entry,
  output nvt_pkg::entry_t    entry,
  output logic               match
);
  import nvt_pkg::*;

  entry_t entry_r;
  logic   match_r;

  // Hold entry: shift down from the neighbor on delete, load on append
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= nb_entry;
    end else if (ctl.load) begin
      entry_r <= req_entry;
    end
  end

  // Capture compare result for the incoming name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cap) begin
      match_r <= occ && names_eq({entry_r.name_high, entry_r.name_low},
                                 {req_entry.name_high, req_entry.name_low});
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ----- rtl/core/name_value_table_add_delete.sv -----
// Ordered name/value table with append and delete-by-name.
// Requests arrive on in_ch (valid/ready); each gives exactly one word on
// out_ch carrying status, position and the entry count after the request.
// Add appends at the current count, or reports full. Delete removes the
// first entry whose name matches (bytes compared up to the first zero byte)
// and moves every later entry down one place, or reports not found.
// Each entry lives in its own cell; on accept every cell compares its name
// against the request in parallel, and when the request commits the cells
// at and above the match take their upper neighbor's entry.
// The result word is registered at commit, which follows the compare cycle
// and waits while a previous result word is still held on out_ch.
// A new request is not taken until the previous one has committed; the
// compare cycle is followed by the commit cycle of the cell row.
// in_ch.ready drops while a request is being processed. If out_ch stalls,
// the result register holds and the next request is still accepted; its
// commit then waits until the pending word is taken.
// Reset clears the entry count and the controller; entry contents are
// undefined until written and are never read while unoccupied.
module name_value_table_add_delete (
  input  logic clk,
  input  logic rst_n,
  nvt_req_if.sink   in_ch,
  nvt_rsp_if.source out_ch
);
  import nvt_pkg::*;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            req_type_r;
  entry_t          req_r;
  entry_t          req_in;
  entry_t          req_mux;
  logic            out_valid_r;
  status_t         status_r, status_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic            accept;
  logic            commit;
  logic            found;
  logic [IDX_W-1:0] hit_idx;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] occ_vec;
  logic [CAPACITY-1:0] prefix_vec;
  cell_ctl_t       ctl [CAPACITY];
  entry_t          cell_entry [CAPACITY];

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign req_in.name_low  = in_ch.name_low;
  assign req_in.name_high = in_ch.name_high;
  assign req_in.value     = in_ch.entry_value;

  // Cells compare against the live input on accept, load the held request later
  assign req_mux = (state_r == ST_IDLE) ? req_in : req_r;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_ch.req_type;
      req_r      <= req_in;
    end
  end

  // Find the first matching cell and the set of cells at or above it
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IDX_W'(i);
    end
    prefix_vec[0] = match_vec[0];
    for (int i = 1; i < CAPACITY; i++) begin
      prefix_vec[i] = prefix_vec[i-1] | match_vec[i];
    end
  end
  assign found = |match_vec;

  // Controller: next state, result and count
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    commit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (!out_valid_r || out_ch.ready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
          if (req_type_r == REQ_ADD) begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              pos_nxt    = '0;
            end else begin
              status_nxt = STAT_ADDED;
              pos_nxt    = count_r[IDX_W-1:0];
              count_nxt  = count_r + CNT_W'(1);
            end
          end else begin
            if (found) begin
              status_nxt = STAT_DELETED;
              pos_nxt    = hit_idx;
              count_nxt  = count_r - CNT_W'(1);
            end else begin
              status_nxt = STAT_NOT_FOUND;
              pos_nxt    = '0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance controller state and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = 4'(pos_r);
  assign out_ch.entry_count = 5'(count_r);

  // Row of cells; on delete the cells at and above the match take their upper neighbor's entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t nb;
    assign occ_vec[i] = (CNT_W'(i) < count_r);
    assign ctl[i].cap   = accept;
    assign ctl[i].shift = commit && (req_type_r == REQ_DEL) && prefix_vec[i]
                          && (CNT_W'(i + 1) < count_r);
    assign ctl[i].load  = commit && (req_type_r == REQ_ADD) && (CNT_W'(i) == count_r);
    if (i == CAPACITY - 1) begin : g_last
      assign nb = cell_entry[i];
    end else begin : g_mid
      assign nb = cell_entry[i+1];
    end

    nvt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[i]),
      .occ       (occ_vec[i]),
      .req_entry (req_mux),
      .nb_entry  (nb),
      .entry     (cell_entry[i]),
      .match     (match_vec[i])
    );
  end

  // Count never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Only occupied cells can report a match
  a_match_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> ((match_vec & ~occ_vec) == '0))
    else $error("match from unoccupied cell");

  // A successful delete drops the count by one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_type_r == REQ_DEL) && found) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not decrement count");

  // A successful add raises the count by one
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_type_r == REQ_ADD) && (count_r < CNT_W'(CAPACITY)))
    |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("add did not increment count");

  // A new request waits until the previous result is committed
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> !in_ch.ready)
    else $error("request accepted while busy");

endmodule
